// ===== hw/rtl/udte_pkg.sv =====
// ----------------------------------------------------------------------------
// udte_pkg: shared types and constants for the utc date to epoch converter
// Payload structs for both channels and the front to back queue, calendar
// constants and the cumulative month table.
// ----------------------------------------------------------------------------
package udte_pkg;

  // input item: broken-down utc time, all fields two's complement
  typedef struct packed {
    logic signed [15:0] years_since_1900;
    logic signed [15:0] month_index;
    logic signed [15:0] day_of_month;
    logic signed [15:0] hour_of_day;
    logic signed [15:0] minute_of_hour;
    logic signed [15:0] second_of_minute;
  } udte_in_t;

  // result item
  typedef struct packed {
    logic [34:0] epoch_seconds;
    logic        conversion_error;
  } udte_out_t;

  // item handed from the front part to the back part
  typedef struct packed {
    logic signed [17:0] days;
    logic signed [15:0] hour;
    logic signed [15:0] minute;
    logic signed [15:0] second;
    logic               err;
  } udte_mid_t;

  // accepted year window (years since 1900), 1969..2039
  localparam int YearLo           = 69;
  localparam int YearHi           = 139;
  // 1970 - 1900
  localparam int EpochOff         = 70;
  localparam int LeapsBeforeEpoch = 17;
  localparam int DaysInYear       = 365;
  localparam int HoursPerDay      = 24;
  localparam int MinsPerHour      = 60;
  localparam int SecsPerMin       = 60;
  localparam int Max31            = 2147483647;

  // floor(x / 3) for x in -8192..8191: bias by 3*2731 to make it positive,
  // then multiply by ceil(2^16 / 3) and keep the upper bits
  localparam int DivBias          = 8193;
  localparam int DivOff           = 2731;
  localparam int Recip3           = 21846;

  // day of year before the first of the month, minus one
  function automatic logic signed [9:0] month_start(input logic [3:0] mon);
    logic signed [9:0] r;
    unique case (mon)
      4'd0:    r = -10'sd1;
      4'd1:    r = 10'sd30;
      4'd2:    r = 10'sd58;
      4'd3:    r = 10'sd89;
      4'd4:    r = 10'sd119;
      4'd5:    r = 10'sd150;
      4'd6:    r = 10'sd180;
      4'd7:    r = 10'sd211;
      4'd8:    r = 10'sd242;
      4'd9:    r = 10'sd272;
      4'd10:   r = 10'sd303;
      4'd11:   r = 10'sd333;
      default: r = 10'sd364;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/udte_fifo.sv =====
// ----------------------------------------------------------------------------
// udte_fifo: small flip-flop queue
// Holds items between the converter parts; reports its fill level so the
// producer side can count credits instead of looking at a full flag.
// ----------------------------------------------------------------------------
module udte_fifo #(
  parameter type item_t = logic,
  parameter int  Depth  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  item_t                      item_i,
  input  logic                       pop_i,
  output item_t                      item_o,
  output logic [$clog2(Depth+1)-1:0] count_o,
  output logic                       empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  // pointer wrap and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign empty_o = (count_q == '0);

  // credit logic upstream must never overrun the queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (count_q < CntW'(Depth)))
    else $error("queue overflow");

  // nothing is taken from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue underflow");

endmodule

// ===== hw/rtl/udte_front.sv =====
// ----------------------------------------------------------------------------
// udte_front: accept, fold the month into the year and build the day count
// Two register stages: the first divides the month by twelve through a
// reciprocal multiply, the second checks the year window; the day count is
// formed on the way into the queue.
// ----------------------------------------------------------------------------
module udte_front import udte_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  udte_in_t                   item_i,
  output logic                       full_o,
  input  logic [$clog2(Depth+1)-1:0] mid_cnt_i,
  output logic                       mid_push_o,
  output udte_mid_t                  mid_item_o
);

  localparam int CntW = $clog2(Depth + 1);

  logic              accept;
  logic [CntW:0]     credit_used;

  logic              s1_v_q;
  udte_in_t          s1_item_q;
  logic [29:0]       s1_prod_q;
  logic              s1_err_q;

  logic              s2_v_q;
  udte_in_t          s2_item_q;
  logic [7:0]        s2_fy_q;
  logic [3:0]        s2_fm_q;
  logic              s2_err_q;

  logic [14:0]       div_u;
  logic [29:0]       div_prod;
  logic              yr_bad;

  logic signed [13:0] quo;
  logic signed [15:0] quo_x;
  logic signed [15:0] fm_full;
  logic signed [16:0] fy;
  logic               fold_err;

  logic signed [17:0] fy_s;
  logic               leap_add;
  logic signed [17:0] days;

  // credits: queue entries plus items still in the two stages
  assign credit_used = (CntW+1)'(mid_cnt_i) + (CntW+1)'(s1_v_q) + (CntW+1)'(s2_v_q);
  assign full_o      = (credit_used >= (CntW+1)'(Depth));
  assign accept      = push_i & ~full_o;

  // stage 1: floor(month / 4) biased positive, times the reciprocal of 3
  always_comb begin
    div_u    = {item_i.month_index[15], item_i.month_index[15:2]} + 15'(DivBias);
    div_prod = 30'(div_u) * 30'(Recip3);
    yr_bad   = (item_i.years_since_1900 < YearLo) || (item_i.years_since_1900 > YearHi);
  end

  // stage 2: quotient, folded month and year, year window
  always_comb begin
    quo      = $signed(14'(s1_prod_q[28:16])) - 14'(DivOff);
    quo_x    = {{2{quo[13]}}, quo};
    fm_full  = s1_item_q.month_index - (quo_x <<< 3) - (quo_x <<< 2);
    fy       = 17'(s1_item_q.years_since_1900) + 17'(quo);
    fold_err = s1_err_q || (fy < YearLo) || (fy > YearHi);
  end

  // day count: years, leap days, month table, leap day after february
  always_comb begin
    fy_s     = $signed({10'd0, s2_fy_q});
    leap_add = (s2_fy_q[1:0] == 2'b00) && (s2_fm_q > 4'd1);
    days     = (fy_s - 18'(EpochOff)) * 18'(DaysInYear)
             + ((fy_s - 18'sd1) >>> 2)
             - 18'(LeapsBeforeEpoch)
             + 18'(month_start(s2_fm_q))
             + $signed({17'd0, leap_add})
             + 18'(s2_item_q.day_of_month);
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    s1_item_q <= item_i;
    s1_prod_q <= div_prod;
    s1_err_q  <= yr_bad;
    s2_item_q <= s1_item_q;
    s2_fy_q   <= fy[7:0];
    s2_fm_q   <= fm_full[3:0];
    s2_err_q  <= fold_err;
  end

  assign mid_push_o        = s2_v_q;
  assign mid_item_o.days   = days;
  assign mid_item_o.hour   = s2_item_q.hour_of_day;
  assign mid_item_o.minute = s2_item_q.minute_of_hour;
  assign mid_item_o.second = s2_item_q.second_of_minute;
  assign mid_item_o.err    = s2_err_q;

  // items in flight never exceed the queue room
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_used <= (CntW+1)'(Depth))
    else $error("front credit count exceeds queue depth");

  // a valid fold leaves the month in range
  a_month_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !s2_err_q) |-> (s2_fm_q < 4'd12))
    else $error("folded month out of range");

endmodule

// ===== hw/rtl/udte_back.sv =====
// ----------------------------------------------------------------------------
// udte_back: days to seconds with negative and limit checks
// Pulls day counts from the queue when the output side has room, scales by
// hours, minutes and seconds over three multiply steps and flags errors.
// ----------------------------------------------------------------------------
module udte_back import udte_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       mid_empty_i,
  input  udte_mid_t                  mid_item_i,
  output logic                       mid_pop_o,
  input  logic [$clog2(Depth+1)-1:0] out_cnt_i,
  output logic                       out_push_o,
  output udte_out_t                  out_item_o
);

  localparam int CntW = $clog2(Depth + 1);

  logic               limit_q;
  logic [CntW:0]      credit_used;

  logic               b1_v_q;
  logic signed [21:0] b1_tot_q;
  logic signed [15:0] b1_min_q;
  logic signed [15:0] b1_sec_q;
  logic               b1_err_q;

  logic               b2_v_q;
  logic signed [27:0] b2_tot_q;
  logic signed [15:0] b2_sec_q;
  logic               b2_err_q;

  logic signed [21:0] tot1;
  logic signed [27:0] tot2;
  logic signed [33:0] tot3;
  logic               err3;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 1'b1;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // take an item only when the output queue can absorb it
  assign credit_used = (CntW+1)'(out_cnt_i) + (CntW+1)'(b1_v_q) + (CntW+1)'(b2_v_q);
  assign mid_pop_o   = ~mid_empty_i & (credit_used < (CntW+1)'(Depth));

  // multiply steps
  always_comb begin
    tot1 = 22'(mid_item_i.days) * 22'(HoursPerDay) + 22'(mid_item_i.hour);
    tot2 = 28'(b1_tot_q) * 28'(MinsPerHour) + 28'(b1_min_q);
    tot3 = 34'(b2_tot_q) * 34'(SecsPerMin) + 34'(b2_sec_q);
    err3 = b2_err_q || (b2_tot_q < 0) || (tot3 < 0) || (limit_q && (tot3 > Max31));
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else begin
      b1_v_q <= mid_pop_o;
      b2_v_q <= b1_v_q;
    end
  end

  // stage payload, errors accumulate
  always_ff @(posedge clk_i) begin
    b1_tot_q <= tot1;
    b1_min_q <= mid_item_i.minute;
    b1_sec_q <= mid_item_i.second;
    b1_err_q <= mid_item_i.err || (mid_item_i.days < 0);
    b2_tot_q <= tot2;
    b2_sec_q <= b1_sec_q;
    b2_err_q <= b1_err_q || (b1_tot_q < 0);
  end

  assign out_push_o                  = b2_v_q;
  assign out_item_o.epoch_seconds    = err3 ? '0 : {1'b0, tot3};
  assign out_item_o.conversion_error = err3;

  // with the limit on, a good result fits in 31 bits
  a_limit_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && limit_q && !err3) |-> (out_item_o.epoch_seconds[34:31] == 4'd0))
    else $error("result above 31-bit limit not flagged");

endmodule

// ===== hw/rtl/utc_date_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// utc_date_to_epoch_seconds: broken-down utc time to unix epoch seconds
//
//   channel  direction  handshake                 payload
//   input    in         push / full               in_i  (udte_in_t)
//   result   out        empty / pop               out_o (udte_out_t)
//   config   in         cfg_we_i, no wait         cfg_wdata_i (31-bit limit enable)
//
// One item per cycle sustained while neither queue backs up; a result passes
// through front stages one and two, the middle queue, two back stages and
// the result queue on its way from acceptance to the output.
// The front and back parts are joined by a QueueDepth-entry queue and each
// fills its queue by credit, so either side stalls alone.
// Reset clears both queues and sets the 31-bit limit; no clearing pass.
// ----------------------------------------------------------------------------
module utc_date_to_epoch_seconds import udte_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  udte_in_t  in_i,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output udte_out_t out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  localparam int CntW = $clog2(QueueDepth + 1);

  logic            mid_push;
  logic            mid_pop;
  logic            mid_empty;
  logic [CntW-1:0] mid_cnt;
  udte_mid_t       mid_wr_item;
  udte_mid_t       mid_rd_item;

  logic            out_push;
  logic            out_pop;
  logic [CntW-1:0] out_cnt;
  udte_out_t       out_wr_item;

  // front: accept and fold into a day count
  udte_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (in_i),
    .full_o     (full),
    .mid_cnt_i  (mid_cnt),
    .mid_push_o (mid_push),
    .mid_item_o (mid_wr_item)
  );

  // queue between front and back
  udte_fifo #(
    .item_t (udte_mid_t),
    .Depth  (QueueDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .item_i  (mid_wr_item),
    .pop_i   (mid_pop),
    .item_o  (mid_rd_item),
    .count_o (mid_cnt),
    .empty_o (mid_empty)
  );

  // back: seconds and error checks
  udte_back #(
    .Depth (QueueDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_rd_item),
    .mid_pop_o   (mid_pop),
    .out_cnt_i   (out_cnt),
    .out_push_o  (out_push),
    .out_item_o  (out_wr_item)
  );

  // result queue
  assign out_pop = pop & ~empty;

  udte_fifo #(
    .item_t (udte_out_t),
    .Depth  (QueueDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .item_i  (out_wr_item),
    .pop_i   (out_pop),
    .item_o  (out_o),
    .count_o (out_cnt),
    .empty_o (empty)
  );

endmodule
